FILE: rtl/srmb_pkg.sv
// shared types, constants and table for the slice ring mesh builder
`timescale 1ns / 1ps
package srmb_pkg;
  localparam int CW = 32;
  localparam int NF = 14;
  localparam int NW = 16;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load_pt;
    logic       commit;
    logic       norm_start;
    logic [2:0] tri_idx;
    logic [1:0] corner;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic norm_done;
  } dp_stat_t;

  // vertex refs: ring*4 + corner, three corners then base, e1 end, e2 end
  localparam logic [2:0] TRI_TAB [8][6] = '{
    '{3'd0, 3'd4, 3'd3, 3'd0, 3'd4, 3'd3}, '{3'd3, 3'd4, 3'd7, 3'd4, 3'd7, 3'd3},
    '{3'd3, 3'd7, 3'd2, 3'd3, 3'd7, 3'd2}, '{3'd2, 3'd7, 3'd6, 3'd7, 3'd6, 3'd2},
    '{3'd2, 3'd6, 3'd1, 3'd2, 3'd6, 3'd1}, '{3'd1, 3'd6, 3'd5, 3'd6, 3'd5, 3'd1},
    '{3'd1, 3'd5, 3'd0, 3'd1, 3'd5, 3'd0}, '{3'd0, 3'd5, 3'd4, 3'd5, 3'd4, 3'd0}
  };

  function automatic logic [2:0] tri_ref(input logic [2:0] t, input logic [2:0] k);
    return (k > 3'd5) ? TRI_TAB[t][3'd5] : TRI_TAB[t][k];
  endfunction
endpackage

FILE: rtl/slice_ring_mesh_builder.sv
// top level of the slice ring mesh builder
`timescale 1ns / 1ps
// Takes 3-D points, five per slice (z negated with saturation on entry), and for every
// slice after the first of a mesh emits 24 vertices, eight triangles joining the previous
// and current rings, each vertex with its triangle's Q1.14 unit normal. Input points are
// taken one per cycle while no slice pair is being emitted, with a pause while the ring
// of a mesh's first slice is committed; after the fifth point of a later slice the
// input stalls while eight normals are formed by one shared sequential unit (edge fit,
// two multiply steps, scale, three squares, a square root and three restoring divides,
// with root and divides skipped when the cross product is zero) and the three vertices
// of each triangle are handed out one per taken item.
module slice_ring_mesh_builder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // point_x, point_y, point_z
  input  logic         in_tuser,   // start_of_mesh
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z
  output logic [4:0]   out_tuser,  // triangle_number, corner_number
  output logic         out_tlast   // last_vertex
);
  srmb_pkg::dp_cmd_t  cmd;
  srmb_pkg::dp_stat_t stat;
  srmb_pkg::point_t   pt, v;
  logic [2:0] pidx;
  logic [srmb_pkg::NW-1:0] nx, ny, nz;
  logic in_fire, out_fire;
  srmb_pkg::coord_t zin;

  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // saturating z negation
  always_comb begin
    zin = in_tdata[95:64];
    pt.x = in_tdata[31:0];
    pt.y = in_tdata[63:32];
    pt.z = (zin == {1'b1, {(srmb_pkg::CW-1){1'b0}}}) ? {1'b0, {(srmb_pkg::CW-1){1'b1}}}
                                                    : -zin;
  end

  srmb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .start_of_mesh(in_tuser),
    .out_fire(out_fire), .stat(stat), .cmd(cmd), .pidx(pidx),
    .in_ready(in_tready), .out_valid(out_tvalid)
  );

  srmb_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .pidx(pidx), .pt_in(pt),
    .stat(stat), .v_out(v), .nx(nx), .ny(ny), .nz(nz)
  );

  assign out_tdata = {nz, ny, nx, v.z, v.y, v.x};
  assign out_tuser = {cmd.corner, cmd.tri_idx};
  assign out_tlast = (cmd.tri_idx == 3'd7) && (cmd.corner == 2'd2);
endmodule

FILE: rtl/srmb_normal.sv
// multi-cycle triangle normal unit: edge fit, cross product, scale, sqrt, divide
`timescale 1ns / 1ps
module srmb_normal (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  srmb_pkg::point_t      pb,
  input  srmb_pkg::point_t      pp,
  input  srmb_pkg::point_t      pq,
  output logic                  done,
  output logic [srmb_pkg::NW-1:0] nx,
  output logic [srmb_pkg::NW-1:0] ny,
  output logic [srmb_pkg::NW-1:0] nz
);
  localparam int EW = srmb_pkg::CW + 1;
  localparam int MW = 64;
  localparam int DW = 30 + srmb_pkg::NF + 1;
  // rounding-add step plus one step per numerator bit
  localparam int DN = DW + 1;
  localparam int NW_L = srmb_pkg::NW;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_EDGE  = 11'b00000000010,
    S_FIT   = 11'b00000000100,
    S_MULA  = 11'b00000001000,
    S_MULB  = 11'b00000010000,
    S_CROSS = 11'b00000100000,
    S_SCALE = 11'b00001000000,
    S_SQ    = 11'b00010000000,
    S_SQRT  = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } st_t;

  st_t st_r, st_nxt;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [MW-1:0] pa_r [3];
  logic signed [MW-1:0] pbp_r [3];
  logic signed [MW-1:0] c_r [3];
  logic [63:0] s_r, res_r, bit_r;
  logic [5:0]  cnt_r;
  logic [1:0]  comp_r;
  logic [DW-1:0] rem_r, quo_r, num_r;
  logic [NW_L-1:0] n_r [3];

  // shift amount that brings an edge into [-2^30, 2^30)
  function automatic logic [1:0] fit_sh(input logic signed [EW-1:0] a,
                                        input logic signed [EW-1:0] b,
                                        input logic signed [EW-1:0] c);
    logic [EW-1:0] m, ma, mb, mc;
    logic [1:0] s;
    ma = a[EW-1] ? -a : a;
    mb = b[EW-1] ? -b : b;
    mc = c[EW-1] ? -c : c;
    m = ma;
    if (mb > m) m = mb;
    if (mc > m) m = mc;
    s = 2'd0;
    if (m[EW-1:30] != '0) s = 2'd1;
    if (m[EW-1:31] != '0) s = 2'd2;
    if (m[EW-1:32] != '0) s = 2'd3;
    return s;
  endfunction

  function automatic logic [MW-1:0] mag64(input logic signed [MW-1:0] v);
    return v[MW-1] ? -v : v;
  endfunction

  // signed product of two fitted edge components (31 bits each)
  function automatic logic signed [MW-1:0] smul(input logic signed [30:0] a,
                                                input logic signed [30:0] b);
    return MW'(a) * MW'(b);
  endfunction

  logic [1:0] s1, s2;
  logic [MW-1:0] cm0, cm1, cm2, cmax;
  logic [6:0] blen;
  logic [MW-1:0] sum_t;
  logic [DW-1:0] trial;
  logic [DW-1:0] rem_sh;

  always_comb begin
    s1 = fit_sh(e1_r[0], e1_r[1], e1_r[2]);
    s2 = fit_sh(e2_r[0], e2_r[1], e2_r[2]);
    cm0 = mag64(c_r[0]);
    cm1 = mag64(c_r[1]);
    cm2 = mag64(c_r[2]);
    cmax = cm0 | cm1 | cm2;
    blen = 7'd0;
    for (int i = 0; i < MW; i++) if (cmax[i]) blen = 7'(i + 1);
    sum_t = res_r + bit_r;
    rem_sh = {rem_r[DW-2:0], num_r[DW-1]};
    trial = rem_sh - DW'(res_r);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (start) st_nxt = S_EDGE;
      S_EDGE:  st_nxt = S_FIT;
      S_FIT:   st_nxt = S_MULA;
      S_MULA:  st_nxt = S_MULB;
      S_MULB:  st_nxt = S_CROSS;
      S_CROSS: st_nxt = (cmax == '0) ? S_OUT : S_SCALE;
      S_SCALE: st_nxt = S_SQ;
      S_SQ:    if (comp_r == 2'd2) st_nxt = S_SQRT;
      S_SQRT:  if (bit_r == '0) st_nxt = S_DIV;
      S_DIV:   if (cnt_r == '0 && comp_r == 2'd2) st_nxt = S_OUT;
      S_OUT:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (start) begin
        e1_r[0] <= EW'(pp.x) - EW'(pb.x);
        e1_r[1] <= EW'(pp.y) - EW'(pb.y);
        e1_r[2] <= EW'(pp.z) - EW'(pb.z);
        e2_r[0] <= EW'(pq.x) - EW'(pb.x);
        e2_r[1] <= EW'(pq.y) - EW'(pb.y);
        e2_r[2] <= EW'(pq.z) - EW'(pb.z);
      end
      S_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1_r[i] <= e1_r[i] >>> s1;
          e2_r[i] <= e2_r[i] >>> s2;
        end
      end
      S_FIT: begin
        pa_r[0] <= smul(e1_r[1][30:0], e2_r[2][30:0]);
        pa_r[1] <= smul(e1_r[2][30:0], e2_r[0][30:0]);
        pa_r[2] <= smul(e1_r[0][30:0], e2_r[1][30:0]);
      end
      S_MULA: begin
        pbp_r[0] <= smul(e1_r[2][30:0], e2_r[1][30:0]);
        pbp_r[1] <= smul(e1_r[0][30:0], e2_r[2][30:0]);
        pbp_r[2] <= smul(e1_r[1][30:0], e2_r[0][30:0]);
      end
      S_MULB: begin
        for (int i = 0; i < 3; i++) c_r[i] <= pa_r[i] - pbp_r[i];
      end
      S_CROSS: begin
        if (cmax == '0) begin
          for (int i = 0; i < 3; i++) n_r[i] <= '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (blen > 7'd30) c_r[i] <= c_r[i] >>> (blen - 7'd30);
            else c_r[i] <= c_r[i] <<< (7'd30 - blen);
          end
        end
        comp_r <= 2'd0;
        s_r <= '0;
      end
      S_SCALE: begin
        pa_r[0] <= MW'(cm0[29:0]) * MW'(cm0[29:0]);
        pa_r[1] <= MW'(cm1[29:0]) * MW'(cm1[29:0]);
        pa_r[2] <= MW'(cm2[29:0]) * MW'(cm2[29:0]);
      end
      S_SQ: begin
        s_r <= s_r + pa_r[comp_r];
        comp_r <= comp_r + 2'd1;
        if (comp_r == 2'd2) begin
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      S_SQRT: begin
        if (bit_r == '0) begin
          // root done, set up the first divide
          comp_r <= 2'd0;
          cnt_r <= 6'(DN);
          rem_r <= '0;
          num_r <= DW'(cm0[30:0]) << srmb_pkg::NF;
        end else if (bit_r > s_r && res_r == '0) begin
          // leading zero pairs run as plain shifts
          bit_r <= bit_r >> 2;
        end else begin
          // one result bit per cycle
          if (s_r >= sum_t) begin
            s_r <= s_r - sum_t;
            res_r <= (res_r >> 1) + bit_r;
          end else res_r <= res_r >> 1;
          bit_r <= bit_r >> 2;
        end
      end
      S_DIV: begin
        if (cnt_r != '0) begin
          if (cnt_r == 6'(DN)) num_r <= num_r + DW'(res_r >> 1);
          else begin
            num_r <= num_r << 1;
            if (rem_sh >= DW'(res_r)) begin
              rem_r <= trial;
              quo_r <= {quo_r[DW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[DW-2:0], 1'b0};
            end
          end
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'(DN)) quo_r <= '0;
        end else begin
          // finish one component, limit and sign it
          if (quo_r > DW'(1 << srmb_pkg::NF))
            n_r[comp_r] <= c_r[comp_r][MW-1] ? NW_L'(-(1 << srmb_pkg::NF))
                                             : NW_L'(1 << srmb_pkg::NF);
          else
            n_r[comp_r] <= c_r[comp_r][MW-1] ? NW_L'(-quo_r) : NW_L'(quo_r);
          comp_r <= comp_r + 2'd1;
          cnt_r <= 6'(DN);
          rem_r <= '0;
          num_r <= DW'((comp_r == 2'd0) ? cm1[30:0] : cm2[30:0]) << srmb_pkg::NF;
        end
      end
      default: ;
    endcase
  end

  assign done = (st_r == S_OUT);
  assign nx = n_r[0];
  assign ny = n_r[1];
  assign nz = n_r[2];
endmodule

FILE: rtl/srmb_datapath.sv
// ring storage, vertex select and normal unit
`timescale 1ns / 1ps
module srmb_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srmb_pkg::dp_cmd_t    cmd,
  input  logic [2:0]           pidx,
  input  srmb_pkg::point_t     pt_in,
  output srmb_pkg::dp_stat_t   stat,
  output srmb_pkg::point_t     v_out,
  output logic [srmb_pkg::NW-1:0] nx,
  output logic [srmb_pkg::NW-1:0] ny,
  output logic [srmb_pkg::NW-1:0] nz
);
  srmb_pkg::point_t prev_r [4];
  srmb_pkg::point_t cur_r [4];
  srmb_pkg::point_t pb, pp, pq;
  logic done;

  function automatic srmb_pkg::point_t sel(input logic [2:0] r,
                                           input srmb_pkg::point_t a [4],
                                           input srmb_pkg::point_t b [4]);
    return r[2] ? b[r[1:0]] : a[r[1:0]];
  endfunction

  // ring writes
  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      if (pidx == 3'd0) cur_r[0] <= pt_in;
      else if (pidx != 3'd1) cur_r[2'(pidx - 3'd1)] <= pt_in;
    end
    if (cmd.commit) begin
      for (int i = 0; i < 4; i++) prev_r[i] <= cur_r[i];
    end
  end

  always_comb begin
    pb = sel(srmb_pkg::tri_ref(cmd.tri_idx, 3'd3), prev_r, cur_r);
    pp = sel(srmb_pkg::tri_ref(cmd.tri_idx, 3'd4), prev_r, cur_r);
    pq = sel(srmb_pkg::tri_ref(cmd.tri_idx, 3'd5), prev_r, cur_r);
    v_out = sel(srmb_pkg::tri_ref(cmd.tri_idx, {1'b0, cmd.corner}), prev_r, cur_r);
  end

  srmb_normal u_norm (
    .clk(clk), .rst_n(rst_n), .start(cmd.norm_start),
    .pb(pb), .pp(pp), .pq(pq), .done(done), .nx(nx), .ny(ny), .nz(nz)
  );

  assign stat.norm_done = done;
endmodule

FILE: rtl/srmb_ctrl.sv
// sequencer: point counting, normal start and vertex emission
`timescale 1ns / 1ps
module srmb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               start_of_mesh,
  input  logic               out_fire,
  input  srmb_pkg::dp_stat_t stat,
  output srmb_pkg::dp_cmd_t  cmd,
  output logic [2:0]         pidx,
  output logic               in_ready,
  output logic               out_valid
);
  typedef enum logic [3:0] {
    C_IN   = 4'b0001,
    C_NORM = 4'b0010,
    C_WAIT = 4'b0100,
    C_EMIT = 4'b1000
  } cst_t;

  cst_t st_r, st_nxt;
  logic [2:0] pis_r, pis_nxt;
  logic       hp_r, hp_nxt;
  logic [2:0] tri_r, tri_nxt;
  logic [1:0] cor_r, cor_nxt;

  assign pidx = start_of_mesh ? 3'd0 : pis_r;
  assign in_ready = (st_r == C_IN);
  assign out_valid = (st_r == C_EMIT);

  always_comb begin
    st_nxt = st_r;
    pis_nxt = pis_r;
    hp_nxt = hp_r;
    tri_nxt = tri_r;
    cor_nxt = cor_r;
    cmd = '0;
    cmd.tri_idx = tri_r;
    cmd.corner = cor_r;
    case (st_r)
      C_IN: if (in_fire) begin
        cmd.load_pt = 1'b1;
        if (pidx == 3'd4) begin
          pis_nxt = 3'd0;
          if (hp_r) begin
            st_nxt = C_NORM;
            tri_nxt = 3'd0;
            cor_nxt = 2'd0;
          end else begin
            hp_nxt = 1'b1;
            st_nxt = C_NORM;
            tri_nxt = 3'd7;
            cor_nxt = 2'd3;
          end
        end else begin
          pis_nxt = pidx + 3'd1;
          if (start_of_mesh) hp_nxt = 1'b0;
        end
      end
      C_NORM: begin
        if (cor_r == 2'd3) begin
          // first slice: only commit
          cmd.commit = 1'b1;
          st_nxt = C_IN;
        end else begin
          cmd.norm_start = 1'b1;
          st_nxt = C_WAIT;
        end
      end
      C_WAIT: if (stat.norm_done) st_nxt = C_EMIT;
      C_EMIT: if (out_fire) begin
        if (cor_r == 2'd2) begin
          cor_nxt = 2'd0;
          tri_nxt = tri_r + 3'd1;
          if (tri_r == 3'd7) begin
            cmd.commit = 1'b1;
            st_nxt = C_IN;
          end else st_nxt = C_NORM;
        end else cor_nxt = cor_r + 2'd1;
      end
      default: st_nxt = C_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IN;
      pis_r <= '0;
      hp_r <= 1'b0;
      tri_r <= '0;
      cor_r <= '0;
    end else begin
      st_r <= st_nxt;
      pis_r <= pis_nxt;
      hp_r <= hp_nxt;
      tri_r <= tri_nxt;
      cor_r <= cor_nxt;
    end
  end
endmodule
